FILE: hdl/ptnq_pkg.sv
// Package with the constants and types of the point table query core.
package ptnq_pkg;
   localparam int Capacity = 64;
   localparam int IdxW = $clog2(Capacity);
   localparam int CntW = $clog2(Capacity + 1);
   localparam int EntW = 64 + 16 + 16;

   localparam logic [2:0] REQ_INSERT = 3'd0;
   localparam logic [2:0] REQ_DEL_KEY = 3'd1;
   localparam logic [2:0] REQ_DEL_XY = 3'd2;
   localparam logic [2:0] REQ_FIND = 3'd3;
   localparam logic [2:0] REQ_NEAREST = 3'd4;
   localparam logic [2:0] REQ_RANGE = 3'd5;

   localparam logic [1:0] ST_DONE = 2'd0;
   localparam logic [1:0] ST_FULL = 2'd1;
   localparam logic [1:0] ST_NONE = 2'd2;
   localparam logic [1:0] ST_HIT = 2'd3;

   typedef enum logic [6:0] {
      S_IDLE  = 7'b0000001,
      S_READ  = 7'b0000010,
      S_SQX   = 7'b0000100,
      S_SQY   = 7'b0001000,
      S_EVAL  = 7'b0010000,
      S_SHIFT = 7'b0100000,
      S_OUT   = 7'b1000000
   } state_type;
endpackage

FILE: hdl/ptnq_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module ptnq_ram #(
   parameter int Width = 8,
   parameter int Depth = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem [Depth];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

FILE: hdl/point_table_nearest_and_range_query_core.sv
// Top level of the point table core: insert, delete, find, nearest and range requests.
// An insert, an unknown request or a request on an empty table goes to S_OUT, which
// registers its result when the output is free. A scan reads each entry in S_READ and
// tests it in S_EVAL; nearest and range use the shared squarer in S_SQX and S_SQY between.
// A delete then moves the later entries down one per cycle; a request is taken only in idle,
// and result stalls hold the scan. Reset empties the table; the RAM itself is not cleared.
module point_table_nearest_and_range_query_core (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // req_tdata: req_type[2:0], name_key[66:3], x_coord[82:67], y_coord[98:83],
   // radius_squared[132:99], zero fill to 135
   input  logic [135:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // rsp_tdata: status[1:0], entry_index[7:2], found_key[71:8], found_x[87:72],
   // found_y[103:88]
   output logic [103:0] rsp_tdata,
   output logic         rsp_tlast
);
   localparam int IdxW = ptnq_pkg::IdxW;
   localparam int CntW = ptnq_pkg::CntW;

   ptnq_pkg::state_type state_ff, state_in;
   logic [CntW-1:0] count_ff, count_in;
   logic [CntW-1:0] idx_ff, idx_in;
   logic [2:0] op_ff, op_in;
   logic [63:0] key_ff, key_in;
   logic signed [15:0] qx_ff, qx_in, qy_ff, qy_in;
   logic [33:0] rad_ff, rad_in;
   logic [33:0] acc_ff, acc_in, best_d_ff, best_d_in;
   logic [IdxW-1:0] best_ff, best_in;
   logic hit_ff, hit_in;
   logic [95:0] ent_ff, ent_in;
   logic [95:0] pend_ff, pend_in;
   logic [1:0] pst_ff, pst_in;
   logic valid_ff, valid_in, last_ff, last_in;
   logic [1:0] st_ff, st_in;
   logic [IdxW-1:0] oidx_ff, oidx_in;
   logic [95:0] odat_ff, odat_in;

   logic wr_en;
   logic [IdxW-1:0] wr_addr, rd_addr;
   logic [95:0] wr_data, rd_data;
   logic signed [16:0] diff;
   logic [16:0] mag;
   logic [33:0] sq;
   logic out_free;
   logic is_last;
   logic ent_match;

   ptnq_ram #(.Width(ptnq_pkg::EntW), .Depth(ptnq_pkg::Capacity)) u_ram (
      .clock(clock), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
      .rd_addr(rd_addr), .rd_data(rd_data)
   );

   // Shared squaring unit: one coordinate difference per cycle.
   always_comb begin
      if (state_ff == ptnq_pkg::S_SQX) begin
         diff = 17'(signed'(ent_ff[79:64])) - 17'(qx_ff);
      end else begin
         diff = 17'(signed'(ent_ff[95:80])) - 17'(qy_ff);
      end
      mag = diff[16] ? 17'(-diff) : diff;
      sq = 34'(mag) * 34'(mag);
   end

   always_comb begin
      case (op_ff)
         ptnq_pkg::REQ_DEL_XY: ent_match = ent_ff[95:64] == {qy_ff, qx_ff};
         ptnq_pkg::REQ_NEAREST: ent_match = (idx_ff == '0) || (acc_ff < best_d_ff);
         ptnq_pkg::REQ_RANGE: ent_match = acc_ff <= rad_ff;
         default: ent_match = ent_ff[63:0] == key_ff;
      endcase
   end

   assign out_free = !valid_ff || rsp_tready;
   assign is_last = (idx_ff + 1'b1) == count_ff;
   assign rd_addr = idx_in[IdxW-1:0];
   assign req_tready = (state_ff == ptnq_pkg::S_IDLE);
   assign rsp_tvalid = valid_ff;
   assign rsp_tlast = last_ff;
   assign rsp_tdata = {odat_ff, oidx_ff, st_ff};

   always_comb begin
      state_in = state_ff; count_in = count_ff; idx_in = idx_ff; op_in = op_ff;
      key_in = key_ff; qx_in = qx_ff; qy_in = qy_ff; rad_in = rad_ff;
      acc_in = acc_ff; best_d_in = best_d_ff; best_in = best_ff; hit_in = hit_ff;
      ent_in = ent_ff; pend_in = pend_ff; pst_in = pst_ff;
      valid_in = valid_ff; last_in = last_ff; st_in = st_ff;
      oidx_in = oidx_ff; odat_in = odat_ff;
      wr_en = 1'b0; wr_addr = count_ff[IdxW-1:0]; wr_data = req_tdata[98:3];
      if (valid_ff && rsp_tready) begin
         valid_in = 1'b0;
      end
      case (state_ff)
         ptnq_pkg::S_IDLE: begin
            if (req_tvalid && req_tready) begin
               op_in = req_tdata[2:0];
               key_in = req_tdata[66:3];
               qx_in = req_tdata[82:67];
               qy_in = req_tdata[98:83];
               rad_in = req_tdata[132:99];
               idx_in = '0;
               hit_in = 1'b0;
               best_in = '0;
               pend_in = '0;
               pst_in = ptnq_pkg::ST_NONE;
               state_in = ptnq_pkg::S_READ;
               if (req_tdata[2:0] == ptnq_pkg::REQ_INSERT) begin
                  state_in = ptnq_pkg::S_OUT;
                  if (count_ff < CntW'(ptnq_pkg::Capacity)) begin
                     wr_en = 1'b1;
                     pst_in = ptnq_pkg::ST_DONE;
                     best_in = count_ff[IdxW-1:0];
                     pend_in = req_tdata[98:3];
                     count_in = count_ff + 1'b1;
                  end else begin
                     pst_in = ptnq_pkg::ST_FULL;
                  end
               end else if (!(req_tdata[2:0] inside {ptnq_pkg::REQ_DEL_KEY,
                     ptnq_pkg::REQ_DEL_XY, ptnq_pkg::REQ_FIND,
                     ptnq_pkg::REQ_NEAREST, ptnq_pkg::REQ_RANGE})
                     || count_ff == '0) begin
                  state_in = ptnq_pkg::S_OUT;
               end
            end
         end
         ptnq_pkg::S_READ: begin
            ent_in = rd_data;
            if (op_ff inside {ptnq_pkg::REQ_NEAREST, ptnq_pkg::REQ_RANGE}) begin
               state_in = ptnq_pkg::S_SQX;
            end else begin
               state_in = ptnq_pkg::S_EVAL;
            end
         end
         ptnq_pkg::S_SQX: begin
            acc_in = sq;
            state_in = ptnq_pkg::S_SQY;
         end
         ptnq_pkg::S_SQY: begin
            acc_in = acc_ff + sq;
            state_in = ptnq_pkg::S_EVAL;
         end
         ptnq_pkg::S_EVAL: begin
            if (out_free) begin
               idx_in = idx_ff + 1'b1;
               state_in = is_last ? ptnq_pkg::S_OUT : ptnq_pkg::S_READ;
               case (op_ff)
                  ptnq_pkg::REQ_DEL_KEY, ptnq_pkg::REQ_DEL_XY: begin
                     if (ent_match) begin
                        valid_in = 1'b1;
                        st_in = ptnq_pkg::ST_DONE;
                        oidx_in = idx_ff[IdxW-1:0];
                        odat_in = ent_ff;
                        last_in = 1'b1;
                        count_in = count_ff - 1'b1;
                        state_in = is_last ? ptnq_pkg::S_IDLE : ptnq_pkg::S_SHIFT;
                     end
                  end
                  ptnq_pkg::REQ_FIND: begin
                     if (ent_match) begin
                        valid_in = 1'b1;
                        st_in = ptnq_pkg::ST_HIT;
                        oidx_in = idx_ff[IdxW-1:0];
                        odat_in = ent_ff;
                        last_in = 1'b1;
                        state_in = ptnq_pkg::S_IDLE;
                     end
                  end
                  ptnq_pkg::REQ_NEAREST: begin
                     pst_in = ptnq_pkg::ST_HIT;
                     if (ent_match) begin
                        best_d_in = acc_ff;
                        best_in = idx_ff[IdxW-1:0];
                        pend_in = ent_ff;
                     end
                  end
                  ptnq_pkg::REQ_RANGE: begin
                     if (ent_match) begin
                        // The held hit goes out once a later hit shows it is not the last.
                        if (hit_ff) begin
                           valid_in = 1'b1;
                           st_in = ptnq_pkg::ST_HIT;
                           oidx_in = best_ff;
                           odat_in = pend_ff;
                           last_in = 1'b0;
                        end
                        hit_in = 1'b1;
                        best_in = idx_ff[IdxW-1:0];
                        pend_in = ent_ff;
                        pst_in = ptnq_pkg::ST_HIT;
                     end
                  end
                  default: state_in = ptnq_pkg::S_IDLE;
               endcase
            end
         end
         ptnq_pkg::S_SHIFT: begin
            wr_en = 1'b1;
            wr_addr = IdxW'(idx_ff - 1'b1);
            wr_data = rd_data;
            idx_in = idx_ff + 1'b1;
            state_in = (idx_ff < count_ff) ? ptnq_pkg::S_SHIFT : ptnq_pkg::S_IDLE;
         end
         ptnq_pkg::S_OUT: begin
            if (out_free) begin
               valid_in = 1'b1;
               st_in = pst_ff;
               oidx_in = best_ff;
               odat_in = pend_ff;
               last_in = 1'b1;
               state_in = ptnq_pkg::S_IDLE;
            end
         end
         default: state_in = ptnq_pkg::S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ptnq_pkg::S_IDLE;
         count_ff <= '0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         valid_ff <= valid_in;
      end
      idx_ff <= idx_in; op_ff <= op_in; key_ff <= key_in; qx_ff <= qx_in;
      qy_ff <= qy_in; rad_ff <= rad_in; acc_ff <= acc_in; best_d_ff <= best_d_in;
      best_ff <= best_in; hit_ff <= hit_in; ent_ff <= ent_in; pend_ff <= pend_in;
      pst_ff <= pst_in; last_ff <= last_in; st_ff <= st_in; oidx_ff <= oidx_in;
      odat_ff <= odat_in;
   end

   a_count: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CntW'(ptnq_pkg::Capacity)) else $error("count above capacity");
   a_busy: assert property (@(posedge clock) disable iff (reset)
      state_ff != ptnq_pkg::S_IDLE |-> !req_tready) else $error("ready while busy");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("result dropped");
   a_single: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[1:0] != ptnq_pkg::ST_HIT |-> rsp_tlast)
      else $error("single result without last");
endmodule

FILE: verif/point_table_nearest_and_range_query_core_tb.sv
// Testbench for the point table query core: directed and random requests against a predictor.
`timescale 1ns / 1ps

class point_table_board;
   bit [63:0] tbl_key [64];
   bit signed [15:0] tbl_x [64];
   bit signed [15:0] tbl_y [64];
   int unsigned count;
   bit [104:0] answers [$];
   int unsigned errors;

   function new();
      count = 0;
      errors = 0;
   endfunction

   function bit [104:0] pack_answer(bit [1:0] st, int unsigned idx, bit valid, bit lst);
      bit [104:0] r;
      r = '0;
      r[1:0] = st;
      if (valid) begin
         r[7:2] = idx[5:0];
         r[71:8] = tbl_key[idx];
         r[87:72] = tbl_x[idx];
         r[103:88] = tbl_y[idx];
      end
      r[104] = lst;
      return r;
   endfunction

   function bit [34:0] sq_dist(bit signed [15:0] ax, bit signed [15:0] ay,
                               bit signed [15:0] bx, bit signed [15:0] by);
      longint dx, dy;
      dx = longint'(ax) - longint'(bx);
      dy = longint'(ay) - longint'(by);
      return 35'(dx * dx + dy * dy);
   endfunction

   function void note_request(bit [135:0] d);
      bit [2:0] req;
      bit [63:0] key;
      bit signed [15:0] x, y;
      bit [33:0] rad;
      bit hit;
      int i, j, best, k, lastk;
      bit [34:0] sq_d, bd;
      req = d[2:0];
      key = d[66:3];
      x = d[82:67];
      y = d[98:83];
      rad = d[132:99];
      case (req)
         ptnq_pkg::REQ_INSERT: begin
            if (count < 64) begin
               tbl_key[count] = key;
               tbl_x[count] = x;
               tbl_y[count] = y;
               answers.push_back(pack_answer(ptnq_pkg::ST_DONE, count, 1, 1));
               count++;
            end else answers.push_back(pack_answer(ptnq_pkg::ST_FULL, 0, 0, 1));
         end
         ptnq_pkg::REQ_DEL_KEY, ptnq_pkg::REQ_DEL_XY: begin
            hit = 0;
            for (i = 0; i < count && !hit; i++) begin
               if (req == ptnq_pkg::REQ_DEL_KEY ? tbl_key[i] == key
                                                : (tbl_x[i] == x && tbl_y[i] == y)) begin
                  hit = 1;
                  answers.push_back(pack_answer(ptnq_pkg::ST_DONE, i, 1, 1));
                  for (j = i; j + 1 < count; j++) begin
                     tbl_key[j] = tbl_key[j + 1];
                     tbl_x[j] = tbl_x[j + 1];
                     tbl_y[j] = tbl_y[j + 1];
                  end
                  count--;
               end
            end
            if (!hit) answers.push_back(pack_answer(ptnq_pkg::ST_NONE, 0, 0, 1));
         end
         ptnq_pkg::REQ_FIND: begin
            hit = 0;
            for (i = 0; i < count && !hit; i++)
               if (tbl_key[i] == key) begin
                  hit = 1;
                  answers.push_back(pack_answer(ptnq_pkg::ST_HIT, i, 1, 1));
               end
            if (!hit) answers.push_back(pack_answer(ptnq_pkg::ST_NONE, 0, 0, 1));
         end
         ptnq_pkg::REQ_NEAREST: begin
            if (count == 0) answers.push_back(pack_answer(ptnq_pkg::ST_NONE, 0, 0, 1));
            else begin
               best = 0;
               bd = 0;
               for (i = 0; i < count; i++) begin
                  sq_d = sq_dist(tbl_x[i], tbl_y[i], x, y);
                  if (i == 0 || sq_d < bd) begin
                     bd = sq_d;
                     best = i;
                  end
               end
               answers.push_back(pack_answer(ptnq_pkg::ST_HIT, best, 1, 1));
            end
         end
         ptnq_pkg::REQ_RANGE: begin
            k = 0;
            lastk = -1;
            for (i = 0; i < count; i++)
               if (sq_dist(tbl_x[i], tbl_y[i], x, y) <= {1'b0, rad}) lastk = i;
            for (i = 0; i < count; i++)
               if (sq_dist(tbl_x[i], tbl_y[i], x, y) <= {1'b0, rad}) begin
                  answers.push_back(pack_answer(ptnq_pkg::ST_HIT, i, 1, i == lastk));
                  k++;
               end
            if (k == 0) answers.push_back(pack_answer(ptnq_pkg::ST_NONE, 0, 0, 1));
         end
         default: answers.push_back(pack_answer(ptnq_pkg::ST_NONE, 0, 0, 1));
      endcase
   endfunction

   function void check_result(bit [103:0] d, bit lst);
      bit [104:0] want, got;
      got = {lst, d};
      if (answers.size() == 0) begin
         errors++;
         if (errors <= 10) $display("Unexpected result transfer %h", got);
         return;
      end
      want = answers.pop_front();
      if (want !== got) begin
         errors++;
         if (errors <= 10)
            $display("Mismatch: status %0d/%0d idx %0d/%0d key %h/%h x %h/%h y %h/%h last %b/%b",
                     want[1:0], got[1:0], want[7:2], got[7:2], want[71:8], got[71:8],
                     want[87:72], got[87:72], want[103:88], got[103:88], want[104], got[104]);
      end
   endfunction
endclass

module point_table_nearest_and_range_query_core_tb;
   localparam logic [2:0] REQ_SPARE6 = 3'd6;
   localparam logic [2:0] REQ_SPARE7 = 3'd7;

   logic clock = 0;
   logic reset = 1;
   logic req_tvalid = 0;
   logic req_tready;
   logic [135:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 0;
   logic [103:0] rsp_tdata;
   logic rsp_tlast;

   point_table_board board = new();
   bit calm = 0;
   bit hold_off = 0;
   longint cycles = 0;
   bit [63:0] used_keys [$];
   bit [31:0] used_xy [$];

   point_table_nearest_and_range_query_core DUT (.*);

   always begin
      #1 clock = 1;
      #1 clock = 0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > 4000000) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) board.check_result(rsp_tdata, rsp_tlast);
   end

   initial begin
      int n;
      @(posedge clock);
      while (1) begin
         @(posedge clock);
         if (hold_off) rsp_tready <= 0;
         else if (!calm && $urandom_range(0, 5) == 0) begin
            rsp_tready <= 0;
            n = $urandom_range(1, 3);
            repeat (n - 1) @(posedge clock);
         end else rsp_tready <= 1;
      end
   end

   task automatic send(bit [2:0] req, bit [63:0] key, bit [15:0] x, bit [15:0] y,
                       bit [33:0] rad);
      int n;
      if (!calm && $urandom_range(0, 4) == 0) begin
         n = $urandom_range(1, 3);
         req_tvalid <= 0;
         repeat (n) @(posedge clock);
      end
      req_tvalid <= 1;
      req_tdata <= {3'b0, rad, y, x, key, req};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      board.note_request({3'b0, rad, y, x, key, req});
      if (req == ptnq_pkg::REQ_INSERT) begin
         used_keys.push_back(key);
         used_xy.push_back({y, x});
      end
   endtask

   task automatic send_random();
      bit [2:0] req;
      bit [63:0] key;
      bit [31:0] xy;
      bit [33:0] rad;
      int r;
      r = $urandom_range(0, 99);
      key = {$urandom, $urandom};
      xy = $urandom;
      if ($urandom_range(0, 1)) xy = {16'($urandom_range(0, 15) - 8), 16'($urandom_range(0, 15) - 8)};
      rad = 34'({$urandom, $urandom});
      if ($urandom_range(0, 2) != 0) rad = 34'($urandom_range(0, 200));
      if (r < 30) req = ptnq_pkg::REQ_INSERT;
      else if (r < 42) req = ptnq_pkg::REQ_DEL_KEY;
      else if (r < 52) req = ptnq_pkg::REQ_DEL_XY;
      else if (r < 64) req = ptnq_pkg::REQ_FIND;
      else if (r < 78) req = ptnq_pkg::REQ_NEAREST;
      else if (r < 96) req = ptnq_pkg::REQ_RANGE;
      else req = $urandom_range(0, 1) ? REQ_SPARE6 : REQ_SPARE7;
      if (used_keys.size() > 0 && $urandom_range(0, 3) != 0) begin
         key = used_keys[$urandom_range(0, used_keys.size() - 1)];
         if (req == ptnq_pkg::REQ_DEL_XY) xy = used_xy[$urandom_range(0, used_xy.size() - 1)];
      end
      send(req, key, xy[15:0], xy[31:16], rad);
   endtask

   initial begin
      int i;
      repeat (11) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      send(ptnq_pkg::REQ_NEAREST, '0, '0, '0, '0);
      send(ptnq_pkg::REQ_RANGE, '0, '0, '0, 34'h3FFFFFFFF);
      send(ptnq_pkg::REQ_FIND, 64'hFFFFFFFFFFFFFFFF, '0, '0, '0);
      send(ptnq_pkg::REQ_DEL_KEY, 64'd1, '0, '0, '0);
      send(ptnq_pkg::REQ_DEL_XY, '0, '0, '0, '0);
      send(ptnq_pkg::REQ_INSERT, 64'hFFFFFFFFFFFFFFFF, 16'h8000, 16'h8000, '0);
      send(ptnq_pkg::REQ_INSERT, '0, 16'h7FFF, 16'h7FFF, '0);
      send(ptnq_pkg::REQ_INSERT, 64'd5, 16'h7FFF, 16'h7FFF, '0);
      send(ptnq_pkg::REQ_NEAREST, '0, 16'h8000, 16'h8000, '0);
      send(ptnq_pkg::REQ_NEAREST, '0, 16'h7FFF, 16'h7FFF, '0);
      send(ptnq_pkg::REQ_RANGE, '0, 16'h8000, 16'h8000, 34'h200000000);
      send(ptnq_pkg::REQ_RANGE, '0, 16'h8000, 16'h8000, 34'h1FFFC0001);
      send(ptnq_pkg::REQ_RANGE, '0, 16'h7FFF, 16'h7FFF, '0);
      send(ptnq_pkg::REQ_FIND, 64'd5, '0, '0, '0);
      send(REQ_SPARE6, '0, '0, '0, '0);
      send(REQ_SPARE7, 64'hFFFFFFFFFFFFFFFF, 16'hFFFF, 16'hFFFF, 34'h3FFFFFFFF);
      send(ptnq_pkg::REQ_DEL_XY, '0, 16'h7FFF, 16'h7FFF, '0);
      send(ptnq_pkg::REQ_DEL_KEY, 64'hFFFFFFFFFFFFFFFF, '0, '0, '0);
      // Fill the table to capacity; the last insert of the loop and one more after it find it full.
      for (i = 0; i < 64; i++) send(ptnq_pkg::REQ_INSERT, 64'(i), 16'(i), 16'(-i), '0);
      send(ptnq_pkg::REQ_INSERT, 64'd99, 16'd1, 16'd1, '0);
      send(ptnq_pkg::REQ_RANGE, '0, '0, '0, 34'h3FFFFFFFF);
      // Long stall on the result side while requests keep coming.
      fork
         begin
            hold_off = 1;
            repeat (600) @(posedge clock);
            hold_off = 0;
         end
         begin
            for (i = 0; i < 8; i++) send(ptnq_pkg::REQ_FIND, 64'(i), '0, '0, '0);
            req_tvalid <= 0;
         end
      join
      @(posedge clock);
      for (i = 0; i < 40; i++) send(ptnq_pkg::REQ_DEL_KEY, 64'(63 - i), '0, '0, '0);
      for (i = 0; i < 250; i++) begin
         if (i >= 215) calm = 1;
         send_random();
      end
      req_tvalid <= 0;
      while (board.answers.size() > 0) @(posedge clock);
      repeat (500) @(posedge clock);
      if (board.errors == 0 && board.answers.size() == 0) $display("RESULT: OK");
      else $display("RESULT: ERROR");
      $finish;
   end
endmodule
